// ----- design/hid_report_message_deframer_unit_defines.svh -----
// assertion macros for the report message deframer
// used by the top level only; expects clk_i and rst_ni in scope at the use site
`ifndef HID_REPORT_MESSAGE_DEFRAMER_UNIT_DEFINES_SVH
`define HID_REPORT_MESSAGE_DEFRAMER_UNIT_DEFINES_SVH

// generic clocked assertion with explicit clock and active-low reset
`define HRMD_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion on the block clock and reset
`define HRMD_ASSERT(lbl, prop, msg) \
  `HRMD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- design/hrmd_pkg.sv -----
// shared types and constants of the report message deframer
// no dependencies; imported by hrmd_step, hrmd_res_buf and the top level
package hrmd_pkg;

  // report geometry
  localparam int unsigned ReportBytes   = 64;
  localparam int unsigned PosW          = $clog2(ReportBytes);
  localparam int unsigned FirstHdrBytes = 9;
  localparam int unsigned ContHdrBytes  = 1;

  // marker bytes
  localparam logic [7:0] MarkStart = 8'h3F;
  localparam logic [7:0] MarkHash  = 8'h23;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_FIRST = 2'd1,
    ST_BAD_CONT  = 2'd2
  } status_e;

  // kind of the report being received, one-hot
  typedef enum logic [1:0] {
    PH_FIRST = 2'b01,
    PH_CONT  = 2'b10
  } phase_e;

  // deframer state
  typedef struct packed {
    logic [PosW-1:0] pos;
    phase_e          phase;
    logic [15:0]     id;
    logic [31:0]     len;
    logic [31:0]     remaining;
    logic            drain;
  } state_t;

  // one result item
  typedef struct packed {
    status_e     status;
    logic [15:0] id;
    logic [31:0] len;
    logic [7:0]  data;
    logic        has;
    logic        last;
  } result_t;

endpackage

// ----- design/hrmd_step.sv -----
// next-state and result logic for one received byte
// depends on hrmd_pkg (state_t, result_t, marker and header constants)
module hrmd_step (
  input  hrmd_pkg::state_t  state_i,
  input  logic [7:0]        byte_i,
  output hrmd_pkg::state_t  state_o,
  output hrmd_pkg::result_t res_o,
  output logic              res_vld_o
);
  import hrmd_pkg::*;

  logic [31:0] rem_dec;
  logic [31:0] new_len;
  logic [7:0]  want;

  assign rem_dec = state_i.remaining - 32'd1;
  assign new_len = {state_i.len[23:0], byte_i};
  assign want    = (state_i.pos == '0) ? MarkStart : MarkHash;

  always_comb begin
    state_o   = state_i;
    res_o     = '{status: ST_OK, id: state_i.id, len: state_i.len,
                  data: 8'd0, has: 1'b0, last: 1'b0};
    res_vld_o = 1'b0;

    // byte handling by report kind and position
    if (!state_i.drain) begin
      unique case (state_i.phase)
        PH_CONT: begin
          if (state_i.pos < PosW'(ContHdrBytes)) begin
            if (byte_i != MarkStart) begin
              res_o.status      = ST_BAD_CONT;
              res_o.last        = 1'b1;
              res_vld_o         = 1'b1;
              state_o.drain     = 1'b1;
              state_o.phase     = PH_FIRST;
              state_o.remaining = '0;
            end
          end else if (state_i.remaining != '0) begin
            state_o.remaining = rem_dec;
            res_o.data        = byte_i;
            res_o.has         = 1'b1;
            res_o.last        = (rem_dec == '0);
            res_vld_o         = 1'b1;
            if (rem_dec == '0) begin
              state_o.drain = 1'b1;
              state_o.phase = PH_FIRST;
            end
          end
        end
        default: begin
          // first report, also taken for unused phase codes
          if (state_i.pos < PosW'(3)) begin
            if (byte_i != want) begin
              res_o             = '{status: ST_BAD_FIRST, id: 16'd0, len: 32'd0,
                                    data: 8'd0, has: 1'b0, last: 1'b1};
              res_vld_o         = 1'b1;
              state_o.drain     = 1'b1;
              state_o.remaining = '0;
            end
          end else if (state_i.pos < PosW'(5)) begin
            state_o.id = {state_i.id[7:0], byte_i};
          end else if (state_i.pos < PosW'(FirstHdrBytes)) begin
            state_o.len = new_len;
            if (state_i.pos == PosW'(FirstHdrBytes - 1)) begin
              state_o.remaining = new_len;
              if (new_len == '0) begin
                res_o.len     = 32'd0;
                res_o.last    = 1'b1;
                res_vld_o     = 1'b1;
                state_o.drain = 1'b1;
              end
            end
          end else if (state_i.remaining != '0) begin
            state_o.remaining = rem_dec;
            res_o.data        = byte_i;
            res_o.has         = 1'b1;
            res_o.last        = (rem_dec == '0);
            res_vld_o         = 1'b1;
            if (rem_dec == '0) begin
              state_o.drain = 1'b1;
              state_o.phase = PH_FIRST;
            end
          end
        end
      endcase
    end

    // report boundary: pick the kind of the next report
    if (state_i.pos == PosW'(ReportBytes - 1)) begin
      state_o.pos = '0;
      if (state_o.drain || state_o.remaining == '0) begin
        state_o.phase     = PH_FIRST;
        state_o.remaining = '0;
      end else begin
        state_o.phase = PH_CONT;
      end
      state_o.drain = 1'b0;
    end else begin
      state_o.pos = state_i.pos + PosW'(1);
    end
  end

endmodule

// ----- design/hrmd_res_buf.sv -----
// two-entry result buffer between the deframer logic and the output channel
// depends on hrmd_pkg (result_t)
module hrmd_res_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hrmd_pkg::result_t push_data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              ready_i,
  output hrmd_pkg::result_t data_o
);
  import hrmd_pkg::*;

  result_t    mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- design/hid_report_message_deframer_unit.sv -----
// Report message deframer top level.
// Input channel: one report byte per request on in_valid_i/in_ready_o/rx_byte_i.
// Reports are ReportBytes long and arrive back to back. A first report opens
// with '?','#','#', a 16-bit big-endian id and a 32-bit big-endian length;
// continuation reports open with '?'. Output channel out_valid_o/out_ready_i
// carries one request per payload byte with id, length and a last mark, one
// empty last request for a zero-length message, and one last request with a
// nonzero status for a bad marker, after which the rest of that report is
// dropped and the next report is taken as a first report.
// A result enters the buffer behind any older results. Throughput: one byte per
// cycle with in_ready_o high; the per-byte work is a counter update and a
// 32-bit decrement and compare between the state registers and the buffer.
// A two-entry result buffer decouples the sides: while the receiver stalls the
// block still accepts bytes until two results wait, then in_ready_o drops.
// Reset clears the position, phase, id, length and count and empties the buffer.
// Depends on hrmd_pkg, hrmd_step, hrmd_res_buf and the defines header.
`include "hid_report_message_deframer_unit_defines.svh"

module hid_report_message_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] msg_type_o,
  output logic [31:0] message_length_o,
  output logic [7:0]  payload_byte_o,
  output logic        has_payload_o,
  output logic        last_o
);
  import hrmd_pkg::*;

  state_t  st_q, st_d;
  result_t res;
  result_t out_res;
  logic    res_vld;
  logic    buf_full;
  logic    in_fire;

  assign in_ready_o = !buf_full;
  assign in_fire    = in_valid_i && in_ready_o;

  // per-byte deframing logic
  hrmd_step u_step (
    .state_i   (st_q),
    .byte_i    (rx_byte_i),
    .state_o   (st_d),
    .res_o     (res),
    .res_vld_o (res_vld)
  );

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{pos: '0, phase: PH_FIRST, id: 16'd0, len: 32'd0,
                remaining: 32'd0, drain: 1'b0};
    end else if (in_fire) begin
      st_q <= st_d;
    end
  end

  // result buffer
  hrmd_res_buf u_res_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire && res_vld),
    .push_data_i (res),
    .full_o      (buf_full),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .data_o      (out_res)
  );

  assign status_o         = out_res.status;
  assign msg_type_o       = out_res.id;
  assign message_length_o = out_res.len;
  assign payload_byte_o   = out_res.data;
  assign has_payload_o    = out_res.has;
  assign last_o           = out_res.last;

  // checks
  `HRMD_ASSERT(a_drain_silent, (in_fire && st_q.drain) |-> !res_vld, "result while draining")
  `HRMD_ASSERT(a_err_last, (out_valid_o && status_o != ST_OK) |-> (last_o && !has_payload_o), "error result not last")
  `HRMD_ASSERT(a_report_wrap, (in_fire && st_q.pos == PosW'(ReportBytes - 1)) |=> (st_q.pos == '0 && !st_q.drain), "report boundary not taken")

endmodule
